// File: hdl/tcce_pkg.sv
package tcce_pkg;

  // widest cell address over the whole parameter range (8 pages of 4096 cells)
  localparam int ADDR_W = 15;
  // page base offset: page number times cells per page
  localparam int BASE_W = 15;
  // address sum before wrap: base plus row product plus column
  localparam int SUM_W  = 18;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_BS      = 8'h08;

  typedef enum logic [3:0] {
    ACT_SET_CURSOR = 4'd0,
    ACT_GET_CURSOR = 4'd1,
    ACT_READ_CELL  = 4'd2,
    ACT_WRITE_CA   = 4'd3,
    ACT_WRITE_C    = 4'd4,
    ACT_TELETYPE   = 4'd5,
    ACT_SCROLL_UP  = 4'd6,
    ACT_SCROLL_DN  = 4'd7,
    ACT_CLEAR      = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    CFG_COLUMNS      = 3'd0,
    CFG_ROWS         = 3'd1,
    CFG_ACTIVE_PAGE  = 3'd2,
    CFG_PAGE_CELLS   = 3'd3,
    CFG_DEFAULT_ATTR = 3'd4,
    CFG_TTY_ATTR     = 3'd5,
    CFG_CURSOR_SHAPE = 3'd6
  } cfg_reg_t;

  // one access to the cell store
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;
  } mem_req_t;

endpackage

// File: hdl/tcce_cell_ram.sv
module tcce_cell_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                clk,
  input  tcce_pkg::mem_req_t  req,
  output logic [15:0]         rdata
);

  logic [15:0] mem [DEPTH];

  // single port store, registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

// File: hdl/tcce_addr_unit.sv
module tcce_addr_unit #(
  parameter int STORE = 16384,
  parameter int AW    = 14
) (
  input  logic                               clk,
  input  logic [7:0]                         mul_row,
  input  logic [7:0]                         cols,
  input  logic [tcce_pkg::BASE_W-1:0]        base,
  input  logic [7:0]                         col,
  output logic [tcce_pkg::ADDR_W-1:0]        addr
);

  localparam int SW    = tcce_pkg::SUM_W;
  localparam int STEPS = SW - AW;

  logic [15:0]   prod_r;
  logic [SW-1:0] sum;

  // row times columns, registered
  always_ff @(posedge clk) begin
    prod_r <= mul_row * cols;
  end

  // add base and column, then wrap into the store by shifted subtracts
  always_comb begin
    sum = SW'(base) + SW'(prod_r) + SW'(col);
    for (int k = STEPS - 1; k >= 0; k--) begin
      if (sum >= (SW'(STORE) << k)) begin
        sum = sum - (SW'(STORE) << k);
      end
    end
    addr = tcce_pkg::ADDR_W'(sum[AW-1:0]);
  end

endmodule

// File: hdl/text_console_cell_engine_core.sv
// A teletype command may end in a scroll. A repeated write handles one character at a time;
// a scroll reads and writes each moved cell, then blanks the vacated cells.
// One command is in flight at a time; the sequencer and the single cell port set the rate.
// Reset clears cursors and loads register defaults; the cell store is not cleared.
module text_console_cell_engine_core #(
  parameter int PAGES          = 8,
  parameter int MAX_PAGE_CELLS = 2048,
  parameter int MAX_COLUMNS    = 128,
  parameter int MAX_ROWS       = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_action,
  input  logic [2:0]  in_page,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_column,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_attribute,
  input  logic [15:0] in_repeat_count,
  input  logic [7:0]  in_lines,
  input  logic [7:0]  in_top_row,
  input  logic [7:0]  in_left_col,
  input  logic [7:0]  in_bottom_row,
  input  logic [7:0]  in_right_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attr,
  output logic [7:0]  out_cursor_row_out,
  output logic [7:0]  out_cursor_col_out,
  output logic [15:0] out_cursor_shape_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int STORE = PAGES * MAX_PAGE_CELLS;
  localparam int AW    = $clog2(STORE);
  localparam int PG_W  = (PAGES > 1) ? $clog2(PAGES) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC,
    S_RD_MUL, S_RD_ISS, S_RD_DAT,
    S_RP_MUL, S_RP_WR,
    S_TT_MUL, S_TT_WR, S_TT_NL,
    S_CP_SMUL, S_CP_RD, S_CP_DMUL, S_CP_WR,
    S_FL_MUL, S_FL_WR,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [7:0]  cols_r;
  logic [6:0]  rows_r;
  logic [2:0]  apage_r;
  logic [11:0] pcells_r;
  logic [7:0]  dattr_r;
  logic [7:0]  tattr_r;
  logic [15:0] shape_r;

  // latched command
  logic [3:0]            act_r;
  logic [PG_W-1:0]       pg_r;
  logic [7:0]            row_r, col_r, ch_r, attr_r, lin_r;
  logic [7:0]            top_r, left_r, bot_r, right_r;
  logic [15:0]           cnt_r;
  logic [7:0]            rattr_r;

  // working registers
  logic [15:0]                 cur_r [PAGES];
  logic [7:0]                  tr_r, tc_r;
  logic [7:0]                  wr_r, wc_r, wrend_r, wleft_r, wright_r, f0_r, f1_r, lines_r;
  logic                        wdown_r;
  logic [7:0]                  fattr_r;
  logic                        hit_r;
  logic [15:0]                 val_r, rdv_r;
  logic [tcce_pkg::BASE_W-1:0] base_r;
  logic                        out_valid_r;

  // effective sizes
  logic [7:0]  rows_eff, cols_eff;
  logic [12:0] pc_eff;
  always_comb begin
    rows_eff = ({1'b0, rows_r} > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : {1'b0, rows_r};
    cols_eff = (cols_r > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : cols_r;
    pc_eff   = ({1'b0, pcells_r} > 13'(MAX_PAGE_CELLS)) ? 13'(MAX_PAGE_CELLS)
                                                        : {1'b0, pcells_r};
  end

  // page number folded into the cursor table
  logic [2:0] pg_fold;
  always_comb begin
    pg_fold = in_page;
    for (int k = 0; k < 8; k++) begin
      if (pg_fold >= 3'(PAGES)) begin
        pg_fold = pg_fold - 3'(PAGES);
      end
    end
  end

  logic [7:0] cur_row, cur_col;
  assign cur_row = cur_r[pg_r][15:8];
  assign cur_col = cur_r[pg_r][7:0];

  logic [7:0] src_row;
  assign src_row = wdown_r ? (wr_r - lines_r) : (wr_r + lines_r);

  // address unit operands per state
  logic [7:0] mul_row, acol;
  always_comb begin
    case (state_r)
      S_RD_MUL:  mul_row = cur_row;
      S_CP_SMUL: mul_row = src_row;
      S_RP_MUL:  mul_row = tr_r;
      S_TT_MUL:  mul_row = tr_r;
      default:   mul_row = wr_r;
    endcase
    case (state_r)
      S_RD_ISS: acol = cur_col;
      S_RP_WR:  acol = tc_r;
      S_TT_WR:  acol = tc_r;
      default:  acol = wc_r;
    endcase
  end

  logic [tcce_pkg::ADDR_W-1:0] addr;
  tcce_addr_unit #(.STORE(STORE), .AW(AW)) u_addr (
    .clk     (clk),
    .mul_row (mul_row),
    .cols    (cols_eff),
    .base    (base_r),
    .col     (acol),
    .addr    (addr)
  );

  // cell store access
  tcce_pkg::mem_req_t req;
  logic [15:0]        rdata;
  always_comb begin
    req.we    = 1'b0;
    req.re    = 1'b0;
    req.addr  = addr;
    req.wdata = val_r;
    case (state_r)
      S_RD_ISS: req.re = (cur_row < rows_eff) && (cur_col < cols_eff);
      S_CP_RD:  req.re = (src_row < rows_eff) && (wc_r < cols_eff);
      S_CP_WR:  req.we = (wr_r < rows_eff) && (wc_r < cols_eff);
      S_FL_WR: begin
        req.we    = (wr_r < rows_eff) && (wc_r < cols_eff);
        req.wdata = {fattr_r, tcce_pkg::BLANK_CHAR};
      end
      S_RP_WR: begin
        req.we    = (tr_r < rows_eff) && (tc_r < cols_eff);
        req.wdata = {rattr_r, ch_r};
      end
      S_TT_WR: begin
        req.we    = (tr_r < rows_eff) && (tc_r < cols_eff);
        req.wdata = {tattr_r, ch_r};
      end
      default: ;
    endcase
  end

  tcce_cell_ram #(.DEPTH(STORE), .AW(AW)) u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // window launch for scroll, clear and teletype scroll
  logic [7:0] l_top, l_bot, l_left, l_right, l_lines, l_attr;
  logic       l_up, l_go;
  logic [8:0] l_height, l_leff;
  state_t     l_state;
  logic [7:0] l_wr, l_wrend, l_f0, l_f1;
  logic       l_down;
  always_comb begin
    if (state_r == S_TT_NL) begin
      l_top = 8'd0; l_bot = rows_eff - 8'd1; l_left = 8'd0; l_right = cols_eff - 8'd1;
      l_lines = 8'd1; l_up = 1'b1; l_attr = tattr_r; l_go = 1'b1;
    end else if (act_r == tcce_pkg::ACT_CLEAR) begin
      l_top = 8'd0; l_bot = rows_eff - 8'd1; l_left = 8'd0; l_right = cols_eff - 8'd1;
      l_lines = 8'd0; l_up = 1'b1; l_attr = attr_r;
      l_go = (rows_eff != 8'd0) && (cols_eff != 8'd0);
    end else begin
      l_top = top_r; l_bot = bot_r; l_left = left_r; l_right = right_r;
      l_lines = lin_r; l_up = (act_r == tcce_pkg::ACT_SCROLL_UP); l_attr = attr_r;
      l_go = 1'b1;
    end
    l_height = {1'b0, l_bot} - {1'b0, l_top} + 9'd1;
    l_leff   = ((l_lines == 8'd0) || ({1'b0, l_lines} > l_height)) ? l_height
                                                                    : {1'b0, l_lines};
    l_wr = l_top; l_wrend = l_bot; l_down = 1'b0; l_f0 = l_top; l_f1 = l_bot;
    if (!l_go || (l_bot < l_top) || (l_right < l_left)) begin
      l_state = S_DONE;
    end else if (l_leff == l_height) begin
      l_state = S_FL_MUL;
    end else if (l_up) begin
      l_state = S_CP_SMUL;
      l_wrend = l_bot - l_leff[7:0];
      l_f0    = l_bot - l_leff[7:0] + 8'd1;
    end else begin
      l_state = S_CP_SMUL;
      l_wr    = l_bot;
      l_wrend = l_top + l_leff[7:0];
      l_down  = 1'b1;
      l_f1    = l_top + l_leff[7:0] - 8'd1;
    end
  end

  logic [7:0] tc_inc;
  assign tc_inc = tc_r + 8'd1;

  // command sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cols_r      <= 8'd80;
      rows_r      <= 7'd25;
      apage_r     <= 3'd0;
      pcells_r    <= 12'd2048;
      dattr_r     <= 8'd7;
      tattr_r     <= 8'd7;
      shape_r     <= 16'd0;
      for (int i = 0; i < PAGES; i++) begin
        cur_r[i] <= 16'd0;
      end
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          tcce_pkg::CFG_COLUMNS:      cols_r   <= cfg_wdata[7:0];
          tcce_pkg::CFG_ROWS:         rows_r   <= cfg_wdata[6:0];
          tcce_pkg::CFG_ACTIVE_PAGE:  apage_r  <= cfg_wdata[2:0];
          tcce_pkg::CFG_PAGE_CELLS:   pcells_r <= cfg_wdata[11:0];
          tcce_pkg::CFG_DEFAULT_ATTR: dattr_r  <= cfg_wdata[7:0];
          tcce_pkg::CFG_TTY_ATTR:     tattr_r  <= cfg_wdata[7:0];
          tcce_pkg::CFG_CURSOR_SHAPE: shape_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r   <= in_action;
            pg_r    <= PG_W'(pg_fold);
            row_r   <= in_row;
            col_r   <= in_column;
            ch_r    <= in_char_code;
            attr_r  <= in_attribute;
            cnt_r   <= in_repeat_count;
            lin_r   <= in_lines;
            top_r   <= in_top_row;
            left_r  <= in_left_col;
            bot_r   <= in_bottom_row;
            right_r <= in_right_col;
            rdv_r   <= 16'd0;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          base_r  <= tcce_pkg::BASE_W'(apage_r) * tcce_pkg::BASE_W'(pc_eff);
          tr_r    <= cur_row;
          tc_r    <= cur_col;
          case (act_r)
            tcce_pkg::ACT_SET_CURSOR: begin
              cur_r[pg_r] <= {row_r, col_r};
              state_r     <= S_DONE;
            end
            tcce_pkg::ACT_READ_CELL:  state_r <= S_RD_MUL;
            tcce_pkg::ACT_WRITE_CA, tcce_pkg::ACT_WRITE_C: begin
              rattr_r <= (act_r == tcce_pkg::ACT_WRITE_CA) ? attr_r : dattr_r;
              state_r <= (cnt_r != 16'd0) ? S_RP_MUL : S_DONE;
            end
            tcce_pkg::ACT_TELETYPE: begin
              if (ch_r == tcce_pkg::CH_CR) begin
                cur_r[pg_r] <= {cur_row, 8'd0};
                state_r     <= S_DONE;
              end else if (ch_r == tcce_pkg::CH_LF) begin
                state_r <= S_TT_NL;
              end else if (ch_r == tcce_pkg::CH_BS) begin
                if (cur_col != 8'd0) begin
                  cur_r[pg_r] <= {cur_row, cur_col - 8'd1};
                end
                state_r <= S_DONE;
              end else begin
                state_r <= S_TT_MUL;
              end
            end
            tcce_pkg::ACT_SCROLL_UP, tcce_pkg::ACT_SCROLL_DN, tcce_pkg::ACT_CLEAR: begin
              if (act_r == tcce_pkg::ACT_CLEAR) begin
                tattr_r  <= attr_r;
                cur_r[0] <= 16'd0;
              end
              state_r  <= l_state;
              wr_r     <= l_wr;
              wrend_r  <= l_wrend;
              wdown_r  <= l_down;
              f0_r     <= l_f0;
              f1_r     <= l_f1;
              lines_r  <= l_leff[7:0];
              wleft_r  <= l_left;
              wright_r <= l_right;
              wc_r     <= l_left;
              fattr_r  <= l_attr;
            end
            default: state_r <= S_DONE;
          endcase
        end
        // read cell at cursor
        S_RD_MUL: state_r <= S_RD_ISS;
        S_RD_ISS: begin
          hit_r   <= req.re;
          state_r <= S_RD_DAT;
        end
        S_RD_DAT: begin
          rdv_r   <= hit_r ? rdata : {dattr_r, tcce_pkg::BLANK_CHAR};
          state_r <= S_DONE;
        end
        // repeated character write, cursor unchanged
        S_RP_MUL: state_r <= S_RP_WR;
        S_RP_WR: begin
          cnt_r <= cnt_r - 16'd1;
          if (tc_inc >= cols_eff) begin
            tc_r <= 8'd0;
            if (tr_r < rows_eff - 8'd1) begin
              tr_r <= tr_r + 8'd1;
            end
          end else begin
            tc_r <= tc_inc;
          end
          state_r <= (cnt_r == 16'd1) ? S_DONE : S_RP_MUL;
        end
        // teletype printable character
        S_TT_MUL: state_r <= S_TT_WR;
        S_TT_WR: begin
          if (tc_inc >= cols_eff) begin
            tc_r    <= 8'd0;
            state_r <= S_TT_NL;
          end else begin
            cur_r[pg_r] <= {tr_r, tc_inc};
            state_r     <= S_DONE;
          end
        end
        // teletype new line, scroll on the last row
        S_TT_NL: begin
          if (({1'b0, tr_r} + 9'd1) < {1'b0, rows_eff}) begin
            cur_r[pg_r] <= {tr_r + 8'd1, tc_r};
            state_r     <= S_DONE;
          end else if ((rows_eff != 8'd0) && (cols_eff != 8'd0)) begin
            cur_r[pg_r] <= {rows_eff - 8'd1, tc_r};
            state_r  <= l_state;
            wr_r     <= l_wr;
            wrend_r  <= l_wrend;
            wdown_r  <= l_down;
            f0_r     <= l_f0;
            f1_r     <= l_f1;
            lines_r  <= l_leff[7:0];
            wleft_r  <= l_left;
            wright_r <= l_right;
            wc_r     <= l_left;
            fattr_r  <= l_attr;
          end else begin
            cur_r[pg_r] <= {tr_r, tc_r};
            state_r     <= S_DONE;
          end
        end
        // window copy: read source cell, write destination cell
        S_CP_SMUL: state_r <= S_CP_RD;
        S_CP_RD: begin
          hit_r   <= req.re;
          state_r <= S_CP_DMUL;
        end
        S_CP_DMUL: begin
          val_r   <= hit_r ? rdata : {dattr_r, tcce_pkg::BLANK_CHAR};
          state_r <= S_CP_WR;
        end
        S_CP_WR: begin
          if (wc_r == wright_r) begin
            wc_r <= wleft_r;
            if (wr_r == wrend_r) begin
              wr_r    <= f0_r;
              wrend_r <= f1_r;
              wdown_r <= 1'b0;
              state_r <= S_FL_MUL;
            end else begin
              wr_r    <= wdown_r ? (wr_r - 8'd1) : (wr_r + 8'd1);
              state_r <= S_CP_SMUL;
            end
          end else begin
            wc_r    <= wc_r + 8'd1;
            state_r <= S_CP_SMUL;
          end
        end
        // window blank fill
        S_FL_MUL: state_r <= S_FL_WR;
        S_FL_WR: begin
          if (wc_r == wright_r) begin
            wc_r <= wleft_r;
            if (wr_r == wrend_r) begin
              state_r <= S_DONE;
            end else begin
              wr_r    <= wr_r + 8'd1;
              state_r <= S_FL_MUL;
            end
          end else begin
            wc_r    <= wc_r + 8'd1;
            state_r <= S_FL_MUL;
          end
        end
        // result transaction
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r          <= 1'b1;
            out_cell_char        <= rdv_r[7:0];
            out_cell_attr        <= rdv_r[15:8];
            out_cursor_row_out   <= cur_row;
            out_cursor_col_out   <= cur_col;
            out_cursor_shape_out <= shape_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // single store port: never read and write together
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.we && req.re))
    else $error("cell store read and write in the same cycle");

  // store accesses stay inside the store
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (req.we || req.re) |-> (32'(req.addr) < STORE))
    else $error("cell store address out of range");

  // an accepted command blocks the input in the next cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a command is in progress");

endmodule
